// File: rtl/faoh_pkg.sv
// Shared types, constants and helpers for the filtered address octet histogram.
package faoh_pkg;

    localparam int ADDR_W     = 32;
    localparam int BIN_W      = 8;
    localparam int BIN_COUNT  = 256;
    localparam int TABLE_AW   = BIN_W + 1;
    localparam int TABLE_DEPTH = 2 * BIN_COUNT;
    localparam int NET_SLOTS  = 3;
    localparam int PLEN_W     = 6;
    localparam int XCNT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXCLUDE_COUNT = 3'd0,
        REG_NET_BASE_A    = 3'd1,
        REG_NET_BASE_B    = 3'd2,
        REG_NET_BASE_C    = 3'd3,
        REG_PREFIX_LEN_A  = 3'd4,
        REG_PREFIX_LEN_B  = 3'd5,
        REG_PREFIX_LEN_C  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    // Control from the pipeline to the counter store.
    // Key is {is_source, first octet}.
    typedef struct packed {
        logic                rd_en;
        logic [TABLE_AW-1:0] rd_key;
        logic                commit;
        logic [TABLE_AW-1:0] s2_key;
        logic                s2_excl;
    } tbl_ctl_t;

    // Network mask for a prefix length; zero gives no bits, above 32 saturates.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
        logic [ADDR_W-1:0] m;
        begin
            if (plen == '0)
            begin
                m = '0;
            end
            else if (plen >= PLEN_W'(ADDR_W))
            begin
                m = '1;
            end
            else
            begin
                m = ~({ADDR_W{1'b1}} >> plen);
            end
            return m;
        end
    endfunction

endpackage

// File: rtl/faoh_if.sv
// Valid/ready channel interfaces for address items and histogram results.
interface faoh_item_if;
    logic                        valid;
    logic                        ready;
    logic [faoh_pkg::ADDR_W-1:0] ip_address;
    logic                        is_source;

    modport source (output valid, output ip_address, output is_source, input ready);
    modport sink   (input valid, input ip_address, input is_source, output ready);
endinterface

interface faoh_result_if #(parameter int COUNTER_WIDTH = 64);
    logic                       valid;
    logic                       ready;
    logic                       excluded;
    logic [faoh_pkg::BIN_W-1:0] bin_index;
    logic [COUNTER_WIDTH-1:0]   bin_count;

    modport source (output valid, output excluded, output bin_index, output bin_count,
                    input ready);
    modport sink   (input valid, input excluded, input bin_index, input bin_count,
                    output ready);
endinterface

// File: rtl/faoh_excl.sv
// Excluded-network registers and the address match against them.
module faoh_excl #(
    parameter int EXCLUDE_ENTRIES = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  faoh_pkg::cfg_write_t        cfg,
    input  logic [faoh_pkg::ADDR_W-1:0] addr,
    output logic                        excluded
);

    logic [faoh_pkg::XCNT_W-1:0] xcnt_reg;
    logic [faoh_pkg::ADDR_W-1:0] base_reg [faoh_pkg::NET_SLOTS];
    logic [faoh_pkg::PLEN_W-1:0] plen_reg [faoh_pkg::NET_SLOTS];
    logic [faoh_pkg::XCNT_W-1:0] used;
    logic [faoh_pkg::XCNT_W-1:0] limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xcnt_reg <= '0;
            for (int i = 0; i < faoh_pkg::NET_SLOTS; i++)
            begin
                base_reg[i] <= '0;
                plen_reg[i] <= '0;
            end
        end
        else if (cfg.we)
        begin
            case (faoh_pkg::cfg_reg_t'(cfg.index))
                faoh_pkg::REG_EXCLUDE_COUNT: xcnt_reg    <= cfg.data[faoh_pkg::XCNT_W-1:0];
                faoh_pkg::REG_NET_BASE_A:    base_reg[0] <= cfg.data[faoh_pkg::ADDR_W-1:0];
                faoh_pkg::REG_NET_BASE_B:    base_reg[1] <= cfg.data[faoh_pkg::ADDR_W-1:0];
                faoh_pkg::REG_NET_BASE_C:    base_reg[2] <= cfg.data[faoh_pkg::ADDR_W-1:0];
                faoh_pkg::REG_PREFIX_LEN_A:  plen_reg[0] <= cfg.data[faoh_pkg::PLEN_W-1:0];
                faoh_pkg::REG_PREFIX_LEN_B:  plen_reg[1] <= cfg.data[faoh_pkg::PLEN_W-1:0];
                faoh_pkg::REG_PREFIX_LEN_C:  plen_reg[2] <= cfg.data[faoh_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign limit = faoh_pkg::XCNT_W'(EXCLUDE_ENTRIES);
    assign used  = (xcnt_reg > limit) ? limit : xcnt_reg;

    // Slots are independent compares; a hit in any slot in use excludes.
    always_comb
    begin
        logic [faoh_pkg::ADDR_W-1:0] m;
        excluded = 1'b0;
        for (int i = 0; i < faoh_pkg::NET_SLOTS; i++)
        begin
            m = faoh_pkg::prefix_mask(plen_reg[i]);
            if ((faoh_pkg::XCNT_W'(i) < used) && ((addr & m) == (base_reg[i] & m)))
            begin
                excluded = 1'b1;
            end
        end
    end

endmodule

// File: rtl/faoh_counts.sv
// Source and destination counter tables with read-modify-write forwarding.
module faoh_counts #(
    parameter int COUNTER_WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  faoh_pkg::tbl_ctl_t       ctl,
    output logic [COUNTER_WIDTH-1:0] count_next,
    output logic                     busy
);

    logic [COUNTER_WIDTH-1:0]         mem [faoh_pkg::TABLE_DEPTH];
    logic [COUNTER_WIDTH-1:0]         rdata_reg;
    logic [faoh_pkg::TABLE_AW-1:0]    lw_key_reg;
    logic [COUNTER_WIDTH-1:0]         lw_val_reg;
    logic                             lw_vld_reg;
    logic [faoh_pkg::TABLE_AW-1:0]    clr_addr_reg;
    logic                             clr_busy_reg;
    logic [COUNTER_WIDTH-1:0]         cur;
    logic                             do_write;

    assign busy = clr_busy_reg;

    // The last write always holds the latest value of its entry, including a
    // write that landed on the same edge as this entry's read.
    assign cur = (lw_vld_reg && (lw_key_reg == ctl.s2_key)) ? lw_val_reg : rdata_reg;

    assign count_next = ctl.s2_excl ? cur : COUNTER_WIDTH'(cur + 1'b1);
    assign do_write   = ctl.commit && !ctl.s2_excl;

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (do_write)
        begin
            mem[ctl.s2_key] <= count_next;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[ctl.rd_key];
        end
        if (do_write)
        begin
            lw_val_reg <= count_next;
            lw_key_reg <= ctl.s2_key;
        end
    end

    // After reset every entry is zeroed, one per cycle, before any transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
            lw_vld_reg   <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (do_write)
            begin
                lw_vld_reg <= 1'b1;
            end
        end
    end

endmodule

// File: rtl/filtered_address_octet_histogram_core.sv
// Filtered first-octet address histogram, top level.
// Takes one IPv4 address per cycle unless held by the result side or the clearing
// pass, and returns one result per address: the excluded flag, the first octet as
// bin, and that bin's count after the transaction in the source or destination
// table. Sustained rate is one transaction per clock while results are accepted;
// the result passes the input, counter read and result registers. The 512-entry
// counter memory is read as a transaction enters the read stage and written as it
// leaves, with the latest write forwarded, so repeated hits on the same bin keep
// full rate. After reset a clearing pass zeroes the counters, one entry per cycle;
// the input is not ready until that pass is done. The user must make configuration
// writes only while no transaction is in flight; the block does not enforce this.
module filtered_address_octet_histogram_core #(
    parameter int EXCLUDE_ENTRIES = 3,
    parameter int COUNTER_WIDTH   = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    faoh_item_if.sink                       item,
    faoh_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [faoh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [faoh_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                          s1_vld_reg;
    logic [faoh_pkg::ADDR_W-1:0]   s1_addr_reg;
    logic                          s1_src_reg;
    logic                          s2_vld_reg;
    logic [faoh_pkg::TABLE_AW-1:0] s2_key_reg;
    logic                          s2_excl_reg;
    logic                          out_vld_reg;
    logic                          out_excl_reg;
    logic [faoh_pkg::TABLE_AW-1:0] out_key_reg;
    logic [COUNTER_WIDTH-1:0]      out_count_reg;

    logic                          out_load;
    logic                          s2_free;
    logic                          s1_free;
    logic                          s1_adv;
    logic                          s2_adv;
    logic                          s1_excl;
    logic [faoh_pkg::TABLE_AW-1:0] s1_key;
    logic [COUNTER_WIDTH-1:0]      count_next;
    logic                          tbl_busy;
    faoh_pkg::cfg_write_t          cfg;
    faoh_pkg::tbl_ctl_t            ctl;

    assign out_load = !out_vld_reg || result.ready;
    assign s2_free  = !s2_vld_reg || out_load;
    assign s1_free  = !s1_vld_reg || s2_free;
    assign s2_adv   = s2_vld_reg && out_load;
    assign s1_adv   = s1_vld_reg && s2_free;
    assign item.ready = s1_free && !tbl_busy;

    assign s1_key = {s1_src_reg, s1_addr_reg[faoh_pkg::ADDR_W-1 -: faoh_pkg::BIN_W]};

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    faoh_excl #(
        .EXCLUDE_ENTRIES (EXCLUDE_ENTRIES)
    ) u_excl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .addr     (s1_addr_reg),
        .excluded (s1_excl)
    );

    assign ctl.rd_en   = s1_adv;
    assign ctl.rd_key  = s1_key;
    assign ctl.commit  = s2_adv;
    assign ctl.s2_key  = s2_key_reg;
    assign ctl.s2_excl = s2_excl_reg;

    faoh_counts #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_counts (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .count_next (count_next),
        .busy       (tbl_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_vld_reg <= item.valid && !tbl_busy;
            end
            if (s2_free)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (out_load)
            begin
                out_vld_reg <= s2_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_addr_reg <= item.ip_address;
            s1_src_reg  <= item.is_source;
        end
        if (s1_adv)
        begin
            s2_key_reg  <= s1_key;
            s2_excl_reg <= s1_excl;
        end
        if (s2_adv)
        begin
            out_excl_reg  <= s2_excl_reg;
            out_key_reg   <= s2_key_reg;
            out_count_reg <= count_next;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.excluded  = out_excl_reg;
    assign result.bin_index = out_key_reg[faoh_pkg::BIN_W-1:0];
    assign result.bin_count = out_count_reg;

    // An empty input register never blocks the input once the tables are clear.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_vld_reg && !tbl_busy) |-> item.ready)
        else $error("input stalled with empty input register");

    // A transaction leaving the input register lands in the read stage.
    a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> s2_vld_reg)
        else $error("transaction lost between input and read stage");

    // Back-to-back counted hits on the same bin and table step by exactly one.
    a_same_bin_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && $past(result.valid && result.ready)
         && !out_excl_reg && (out_key_reg == $past(out_key_reg)))
        |-> (out_count_reg == COUNTER_WIDTH'($past(out_count_reg) + 1'b1)))
        else $error("forwarded count does not step by one");

endmodule
